>>> sv/slt_pkg.sv
// Shared types and constants for the sorted list table.
// Used by the cell, the top level and the checker; depends on nothing.
package slt_pkg;

  localparam int DATA_W           = 32;
  localparam int MODE_W           = 2;
  localparam int STATUS_W         = 2;
  localparam int POS_W            = 4;
  localparam int COUNT_W          = 5;
  localparam int DEFAULT_CAPACITY = 16;
  localparam int IN_TDATA_W       = 40;
  localparam int OUT_TDATA_W      = 16;

  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

  typedef struct packed {
    logic                     cmp;
    logic                     ins;
    logic                     del;
    logic signed [DATA_W-1:0] value;
  } slt_ctrl_t;

endpackage

>>> sv/slt_cell.sv
// One cell of the sorted list table: holds one entry and its compare flags.
// Depends on slt_pkg.
module slt_cell import slt_pkg::*; (
  input  logic                     clk,
  input  slt_ctrl_t                ctrl,
  input  logic                     occ,
  input  logic                     left_lt,
  input  logic signed [DATA_W-1:0] left_entry,
  input  logic signed [DATA_W-1:0] right_entry,
  output logic signed [DATA_W-1:0] entry,
  output logic                     lt,
  output logic                     first,
  output logic                     hit
);

  logic eq;

  assign first = !lt && left_lt;
  assign hit   = eq && left_lt;

  always_ff @(posedge clk) begin
    if (ctrl.cmp) begin
      lt <= occ && (entry < ctrl.value);
      eq <= occ && (entry == ctrl.value);
    end
    if (ctrl.ins && !lt) begin
      entry <= first ? ctrl.value : left_entry;
    end else if (ctrl.del && !lt) begin
      entry <= right_entry;
    end
  end

endmodule

>>> sv/sorted_list_table.sv
// Top level of the sorted list table: request register, sequencer, cell row
// and result register. Depends on slt_pkg and slt_cell.
//
// Usage:
//   Requests arrive on s_tvalid/s_tready/s_tdata (mode, value); each gives
//   one result on m_tvalid/m_tready/m_tdata (status, position, entry_count).
//   Insert places the value before the first stored value not smaller;
//   delete removes the first equal value; search reports it. A full table
//   refuses an insert with status table full.
//   Each request passes through capture, a compare step in which every
//   cell compares its entry with the value, and an update step in which
//   the row shifts one place on an insert or delete and the result
//   register is loaded. The result is registered when the update step
//   completes; a new request is taken only after the previous one has
//   passed the compare and update steps through the cell row.
//   A new request is taken while a result still waits in the output
//   register; if the receiver stalls, the update cycle holds until the
//   waiting result is taken.
//   Reset empties the table at once; no clearing pass is needed.
module sorted_list_table import slt_pkg::*; #(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // mode[1:0], value[33:2], zero[39:34]
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata    // status[1:0], position[5:2], entry_count[10:6]
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;

  logic [1:0]               state;
  logic [1:0]               state_next;
  logic [MODE_W-1:0]        req_mode;
  logic signed [DATA_W-1:0] req_value;
  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         count_next;
  logic [STATUS_W-1:0]      res_status;
  logic [POS_W-1:0]         res_pos;
  logic [COUNT_W-1:0]       res_count;

  slt_ctrl_t                ctrl;
  logic signed [DATA_W-1:0] entries [CAPACITY];
  logic [CAPACITY-1:0]      occ_vec;
  logic [CAPACITY-1:0]      lt_vec;
  logic [CAPACITY-1:0]      first_vec;
  logic [CAPACITY-1:0]      hit_vec;

  logic                     upd_go;
  logic                     full;
  logic                     found;
  logic [IDX_W-1:0]         pos_idx;
  logic [IDX_W+POS_W-1:0]   pos_ext;
  logic [CNT_W+COUNT_W-1:0] cnt_ext;
  logic [STATUS_W-1:0]      status_next;
  logic [POS_W-1:0]         pos_next;

  assign s_tready = (state == S_IDLE);
  assign upd_go   = (state == S_UPD) && (!m_tvalid || m_tready);
  assign full     = (count == CNT_W'(CAPACITY));
  assign found    = |hit_vec;

  always_comb begin
    pos_idx = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (first_vec[i]) begin
        pos_idx = pos_idx | IDX_W'(i);
      end
    end
  end

  assign pos_ext = {{POS_W{1'b0}}, pos_idx};

  always_comb begin
    status_next = ST_NOT_FOUND;
    pos_next    = '0;
    count_next  = count;
    case (req_mode)
      MODE_INSERT: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          status_next = ST_OK;
          pos_next    = pos_ext[POS_W-1:0];
          count_next  = count + CNT_W'(1);
        end
      end
      MODE_DELETE, MODE_SEARCH: begin
        if (found) begin
          status_next = ST_OK;
          pos_next    = pos_ext[POS_W-1:0];
          if (req_mode == MODE_DELETE) begin
            count_next = count - CNT_W'(1);
          end
        end
      end
      default: begin
        status_next = ST_NOT_FOUND;
      end
    endcase
  end

  assign cnt_ext = {{COUNT_W{1'b0}}, count_next};

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (s_tvalid) state_next = S_CMP;
      S_CMP:   state_next = S_UPD;
      S_UPD:   if (upd_go) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (upd_go) begin
        count    <= count_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      req_mode  <= s_tdata[MODE_W-1:0];
      req_value <= s_tdata[MODE_W+DATA_W-1:MODE_W];
    end
    if (upd_go) begin
      res_status <= status_next;
      res_pos    <= pos_next;
      res_count  <= cnt_ext[COUNT_W-1:0];
    end
  end

  assign m_tdata = {{(OUT_TDATA_W - STATUS_W - POS_W - COUNT_W){1'b0}},
                    res_count, res_pos, res_status};

  assign ctrl.cmp   = (state == S_CMP);
  assign ctrl.ins   = upd_go && (req_mode == MODE_INSERT) && !full;
  assign ctrl.del   = upd_go && (req_mode == MODE_DELETE) && found;
  assign ctrl.value = req_value;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic                     left_lt;
    logic signed [DATA_W-1:0] left_entry;
    logic signed [DATA_W-1:0] right_entry;

    assign occ_vec[g] = (count > CNT_W'(g));

    if (g == 0) begin : g_head
      assign left_lt    = 1'b1;
      assign left_entry = req_value;
    end else begin : g_body
      assign left_lt    = lt_vec[g-1];
      assign left_entry = entries[g-1];
    end

    if (g == CAPACITY - 1) begin : g_tail
      assign right_entry = entries[g];
    end else begin : g_inner
      assign right_entry = entries[g+1];
    end

    slt_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occ         (occ_vec[g]),
      .left_lt     (left_lt),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .entry       (entries[g]),
      .lt          (lt_vec[g]),
      .first       (first_vec[g]),
      .hit         (hit_vec[g])
    );
  end

endmodule

>>> sv/slt_checker.sv
// Port-level checks for the sorted list table, bound to the top level.
// Depends on slt_pkg and sorted_list_table.
module slt_checker import slt_pkg::*; #(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata
);

  logic [STATUS_W-1:0] status;
  logic [POS_W-1:0]    position;

  assign status   = m_tdata[STATUS_W-1:0];
  assign position = m_tdata[STATUS_W+POS_W-1:STATUS_W];

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result dropped or changed while stalled");

  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result shown after reset");

  a_miss_pos: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (status == ST_FULL || status == ST_NOT_FOUND) |-> position == '0)
    else $error("refused or missed request carries a position");

  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> status == ST_OK || status == ST_NOT_FOUND || status == ST_FULL)
    else $error("status code out of range");

  a_no_accept_after: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second request taken while one is in flight");

endmodule

bind sorted_list_table slt_checker #(.CAPACITY(CAPACITY)) u_slt_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
